>>> rtl/core/calsr_pkg.sv
package calsr_pkg;

  localparam int FRAME_W   = 32;
  localparam int HIGH_W    = 16;
  localparam int PERIOD_W  = 16;
  localparam int GAIN_W    = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN     = 2'd2;

  localparam logic [HIGH_W-1:0]   HIGH_RESET   = 16'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd65536;

  typedef struct packed {
    logic [HIGH_W-1:0]   clock_high;
    logic [PERIOD_W-1:0] clock_period;
    logic [GAIN_W-1:0]   gain;
  } calsr_cfg_t;

  // One tick's worth of front-end outcome, waiting for the scaling back end.
  typedef struct packed {
    logic               clock_level;
    logic               busy;
    logic               zero_done;
    logic               read_done;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] offset;
  } calsr_rec_t;

endpackage

>>> rtl/core/calsr_if.sv
interface calsr_in_if;
  logic                           valid;
  logic                           ready;
  logic [calsr_pkg::MODE_W-1:0]   mode;
  logic                           data_level;

  modport source(output valid, mode, data_level, input ready);
  modport sink(input valid, mode, data_level, output ready);
endinterface

interface calsr_out_if;
  logic                                valid;
  logic                                ready;
  logic                                clock_level;
  logic                                busy_res;
  logic                                result_valid;
  logic                                zero_done;
  logic signed [calsr_pkg::FRAME_W-1:0] measurement;
  logic                                saturated;

  modport source(output valid, clock_level, busy_res, result_valid, zero_done,
                 measurement, saturated, input ready);
  modport sink(input valid, clock_level, busy_res, result_valid, zero_done,
               measurement, saturated, output ready);
endinterface

interface calsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [calsr_pkg::CFG_IDX_W-1:0]   index;
  logic [calsr_pkg::CFG_DAT_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/calsr_front.sv
module calsr_front #(
  parameter int FRAME_BITS   = 32,
  parameter int VOTE_SAMPLES = 5,
  parameter int TICK_WIDTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic [calsr_pkg::MODE_W-1:0]        mode,
  input  logic                                data_level,
  input  logic                                cfg_take,
  input  logic [calsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [calsr_pkg::CFG_DAT_W-1:0]     cfg_data,
  output calsr_pkg::calsr_cfg_t               cfg,
  output calsr_pkg::calsr_rec_t               rec
);

  localparam int CW  = ((TICK_WIDTH > calsr_pkg::PERIOD_W) ? TICK_WIDTH
                                                           : calsr_pkg::PERIOD_W) + 1;
  localparam int BW  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int VW  = $clog2(VOTE_SAMPLES + 1);
  localparam logic [CW-1:0] TICK_LIM  = CW'(1) << TICK_WIDTH;
  localparam logic [CW-1:0] VOTE_LIM  = CW'(VOTE_SAMPLES);
  localparam logic [VW-1:0] VOTE_THR  = VW'(VOTE_SAMPLES / 2 + 1);
  localparam logic [BW-1:0] LAST_BIT  = BW'(FRAME_BITS - 1);

  calsr_pkg::calsr_cfg_t cfg_r;

  logic                          busy_r, busy_nxt;
  logic                          oz_r, oz_nxt;
  logic [BW-1:0]                 bit_r, bit_nxt;
  logic [TICK_WIDTH-1:0]         tick_r, tick_nxt;
  logic [VW-1:0]                 votes_r, votes_nxt;
  logic [calsr_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [calsr_pkg::FRAME_W-1:0] offset_r, offset_nxt;

  logic                          active, oz, bit_end, last_bit, clk_lvl;
  logic [BW-1:0]                 bi;
  logic [TICK_WIDTH-1:0]         tc;
  logic [VW-1:0]                 hv, hv_new;
  logic [calsr_pkg::FRAME_W-1:0] fs;
  logic [CW-1:0]                 per_c, high_c, t, samp;

  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_high   <= calsr_pkg::HIGH_RESET;
      cfg_r.clock_period <= calsr_pkg::PERIOD_RESET;
      cfg_r.gain         <= calsr_pkg::GAIN_RESET;
    end else if (cfg_take) begin
      case (cfg_index)
        calsr_pkg::REG_CLOCK_HIGH:   cfg_r.clock_high   <= cfg_data[calsr_pkg::HIGH_W-1:0];
        calsr_pkg::REG_CLOCK_PERIOD: cfg_r.clock_period <= cfg_data[calsr_pkg::PERIOD_W-1:0];
        calsr_pkg::REG_CAL_GAIN:     cfg_r.gain         <= cfg_data[calsr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active = busy_r || (mode == calsr_pkg::MODE_READ) || (mode == calsr_pkg::MODE_ZERO);
    oz     = busy_r ? oz_r : (mode == calsr_pkg::MODE_ZERO);
    bi     = busy_r ? bit_r : '0;
    tc     = busy_r ? tick_r : '0;
    hv     = busy_r ? votes_r : '0;
    fs     = busy_r ? frame_r : '0;

    per_c = CW'(cfg_r.clock_period);
    if (per_c == '0) per_c = CW'(1);
    if (per_c > TICK_LIM) per_c = TICK_LIM;
    high_c = CW'(cfg_r.clock_high);
    if (high_c > per_c) high_c = per_c;
    t = CW'(tc);
    if (t >= per_c) t = per_c - CW'(1);
    samp = (high_c == '0) ? '0 : high_c - CW'(1);

    clk_lvl  = t < high_c;
    bit_end  = (t + CW'(1)) >= per_c;
    last_bit = bi >= LAST_BIT;

    hv_new = hv;
    if (!oz && clk_lvl && (t < VOTE_LIM) && data_level) hv_new = hv + VW'(1);

    frame_nxt = fs;
    if (oz && (t == samp) && data_level) frame_nxt[bi] = 1'b1;
    if (bit_end && !oz && (hv_new >= VOTE_THR)) frame_nxt[bi] = 1'b1;

    busy_nxt   = busy_r;
    oz_nxt     = oz_r;
    bit_nxt    = bit_r;
    tick_nxt   = tick_r;
    votes_nxt  = votes_r;
    offset_nxt = offset_r;
    if (active) begin
      oz_nxt = oz;
      if (bit_end) begin
        votes_nxt = '0;
        tick_nxt  = '0;
        if (last_bit) begin
          busy_nxt = 1'b0;
          bit_nxt  = '0;
          if (oz) offset_nxt = frame_nxt;
        end else begin
          busy_nxt = 1'b1;
          bit_nxt  = bi + BW'(1);
        end
      end else begin
        busy_nxt  = 1'b1;
        votes_nxt = hv_new;
        tick_nxt  = TICK_WIDTH'(t + CW'(1));
        bit_nxt   = bi;
      end
    end

    rec.clock_level = active && clk_lvl;
    rec.busy        = active;
    rec.zero_done   = active && bit_end && last_bit && oz;
    rec.read_done   = active && bit_end && last_bit && !oz;
    rec.frame       = frame_nxt;
    rec.offset      = offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      oz_r     <= 1'b0;
      bit_r    <= '0;
      tick_r   <= '0;
      votes_r  <= '0;
      frame_r  <= '0;
      offset_r <= '0;
    end else if (take) begin
      busy_r  <= busy_nxt;
      oz_r    <= oz_nxt;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      votes_r <= votes_nxt;
      if (active) frame_r <= frame_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

>>> rtl/core/calsr_queue.sv
module calsr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  calsr_pkg::calsr_rec_t push_rec,
  output logic                  full,
  input  logic                  pop,
  output calsr_pkg::calsr_rec_t head_rec,
  output logic                  empty
);

  calsr_pkg::calsr_rec_t entries [calsr_pkg::QUEUE_DEPTH];

  logic [calsr_pkg::QUEUE_PTR_W-1:0] wr_r, rd_r;
  logic [calsr_pkg::QUEUE_CNT_W-1:0] cnt_r;

  assign full     = cnt_r == calsr_pkg::QUEUE_CNT_W'(calsr_pkg::QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign head_rec = entries[rd_r];

  always_ff @(posedge clk) begin
    if (push) entries[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + calsr_pkg::QUEUE_PTR_W'(1);
      if (pop)  rd_r <= rd_r + calsr_pkg::QUEUE_PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + calsr_pkg::QUEUE_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - calsr_pkg::QUEUE_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/core/calsr_back.sv
module calsr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rec_avail,
  input  calsr_pkg::calsr_rec_t               rec,
  output logic                                rec_pop,
  input  logic [calsr_pkg::GAIN_W-1:0]        gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_clock_level,
  output logic                                out_busy_res,
  output logic                                out_result_valid,
  output logic                                out_zero_done,
  output logic signed [calsr_pkg::FRAME_W-1:0] out_measurement,
  output logic                                out_saturated
);

  localparam int MW = calsr_pkg::FRAME_W + 1;
  localparam int HW = calsr_pkg::GAIN_W / 2;
  localparam int PW = MW + HW;
  localparam int QW = PW + 1;
  localparam logic [QW-1:0] POS_MAX = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0] NEG_MAX = QW'(33'h0_8000_0000);

  typedef struct packed {
    logic clock_level;
    logic busy;
    logic zero_done;
    logic read_done;
  } flags_t;

  logic            en;
  logic            a_v_r, b_v_r, o_v_r;
  flags_t          a_f_r, b_f_r;
  logic            a_neg_r, b_neg_r;
  logic [MW-1:0]   a_mag_r;
  logic [PW-1:0]   b_lo_r, b_hi_r;

  logic signed [MW-1:0] diff;
  logic [QW-1:0]        q;
  logic [calsr_pkg::FRAME_W-1:0] meas;
  logic                 sat;

  assign en      = !o_v_r || out_ready;
  assign rec_pop = en && rec_avail;

  assign diff = $signed({rec.frame[calsr_pkg::FRAME_W-1], rec.frame})
              - $signed({rec.offset[calsr_pkg::FRAME_W-1], rec.offset});

  // The 33 by 32 product is split over the two halves of the gain.
  always_comb begin
    q    = QW'(b_hi_r) + QW'(b_lo_r >> HW);
    sat  = 1'b0;
    meas = '0;
    if (b_f_r.read_done) begin
      if (!b_neg_r) begin
        if (q > POS_MAX) begin
          sat  = 1'b1;
          meas = POS_MAX[calsr_pkg::FRAME_W-1:0];
        end else begin
          meas = q[calsr_pkg::FRAME_W-1:0];
        end
      end else begin
        if (q > NEG_MAX) begin
          sat  = 1'b1;
          meas = NEG_MAX[calsr_pkg::FRAME_W-1:0];
        end else begin
          meas = '0 - q[calsr_pkg::FRAME_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= rec_avail;
      b_v_r <= a_v_r;
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f_r   <= '{rec.clock_level, rec.busy, rec.zero_done, rec.read_done};
      a_neg_r <= diff < 0;
      a_mag_r <= (diff < 0) ? MW'(-diff) : MW'(diff);
      b_f_r   <= a_f_r;
      b_neg_r <= a_neg_r;
      b_lo_r  <= PW'(a_mag_r) * PW'(gain[HW-1:0]);
      b_hi_r  <= PW'(a_mag_r) * PW'(gain[calsr_pkg::GAIN_W-1:HW]);
      out_clock_level  <= b_f_r.clock_level;
      out_busy_res     <= b_f_r.busy;
      out_result_valid <= b_f_r.read_done;
      out_zero_done    <= b_f_r.zero_done;
      out_measurement  <= $signed(meas);
      out_saturated    <= sat;
    end
  end

  assign out_valid = o_v_r;

endmodule

>>> rtl/core/caliper_serial_reader.sv
// A tick transfer is answered by its result transfer after the front sequencer
// and queue write, magnitude stage, split multiply and saturate registers.
// Throughput: one tick per cycle while the queue is not full; it absorbs short
// output stalls. Every accepted tick yields exactly one result.
// Synchronous active-low reset returns the reader to idle with a zero offset
// and restores the default clock timing and unity gain.
module caliper_serial_reader #(
  parameter int FRAME_BITS   = 32,
  parameter int VOTE_SAMPLES = 5,
  parameter int TICK_WIDTH   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  calsr_in_if.sink     in_ch,
  calsr_out_if.source  out_ch,
  calsr_cfg_if.sink    cfg_ch
);

  calsr_pkg::calsr_cfg_t cfg;
  calsr_pkg::calsr_rec_t front_rec, head_rec;
  logic                  q_full, q_empty, q_pop, take;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign take         = in_ch.valid && !q_full;

  calsr_front #(
    .FRAME_BITS  (FRAME_BITS),
    .VOTE_SAMPLES(VOTE_SAMPLES),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .mode      (in_ch.mode),
    .data_level(in_ch.data_level),
    .cfg_take  (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg       (cfg),
    .rec       (front_rec)
  );

  calsr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (take),
    .push_rec(front_rec),
    .full    (q_full),
    .pop     (q_pop),
    .head_rec(head_rec),
    .empty   (q_empty)
  );

  calsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_avail       (!q_empty),
    .rec             (head_rec),
    .rec_pop         (q_pop),
    .gain            (cfg.gain),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_clock_level (out_ch.clock_level),
    .out_busy_res    (out_ch.busy_res),
    .out_result_valid(out_ch.result_valid),
    .out_zero_done   (out_ch.zero_done),
    .out_measurement (out_ch.measurement),
    .out_saturated   (out_ch.saturated)
  );

endmodule

>>> rtl/core/calsr_chk.sv
module calsr_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 busy_res,
  input logic                                 clock_level,
  input logic                                 result_valid,
  input logic                                 zero_done,
  input logic signed [calsr_pkg::FRAME_W-1:0] measurement,
  input logic                                 saturated
);

  // A frame ends either as a read or as a zero capture, never both.
  a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(result_valid && zero_done))
    else $error("read and zero capture completed on the same tick");

  // Clock line and completions only appear inside a frame.
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (clock_level || result_valid || zero_done) |-> busy_res)
    else $error("frame activity reported while not busy");

  // Measurement and clip flag are quiet unless a read completes.
  a_quiet_meas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !result_valid |-> (measurement == '0) && !saturated)
    else $error("measurement driven without a completed read");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(measurement)
                                && $stable(result_valid))
    else $error("stalled result transfer changed");

endmodule

bind caliper_serial_reader calsr_chk u_calsr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .busy_res    (out_ch.busy_res),
  .clock_level (out_ch.clock_level),
  .result_valid(out_ch.result_valid),
  .zero_done   (out_ch.zero_done),
  .measurement (out_ch.measurement),
  .saturated   (out_ch.saturated)
);

>>> tb/sv/caliper_serial_reader_test.sv
module caliper_serial_reader_test;

  localparam logic [calsr_pkg::MODE_W-1:0]    MODE_IDLE    = 2'd0;
  localparam logic [calsr_pkg::MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [calsr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int VOTE_COUNT      = 5;
  localparam int VOTE_MAJORITY   = 3;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int DIRECTED_PERIOD = 11;

  typedef struct packed {
    logic                          clock_level;
    logic                          busy_res;
    logic                          result_valid;
    logic                          zero_done;
    logic [calsr_pkg::FRAME_W-1:0] measurement;
    logic                          saturated;
  } reading_t;

  typedef struct packed {
    logic     typed;
    reading_t value;
  } typed_reading_t;

  typedef struct packed {
    logic [calsr_pkg::MODE_W-1:0] mode;
    logic                         data;
    logic                         typed;
    logic                         clock_level;
    logic                         busy_res;
  } directed_tick_t;

  typedef struct packed {
    logic [calsr_pkg::HIGH_W-1:0]   high;
    logic [calsr_pkg::PERIOD_W-1:0] period;
    logic [calsr_pkg::GAIN_W-1:0]   gain;
    logic                           random_gain;
    logic [7:0]                     frames;
  } timing_setting_t;

  // The reset clock-high time of ten ticks with an eleven-tick bit period: a zero
  // capture starts on the fifth row, and requests that arrive mid-frame are dropped.
  localparam directed_tick_t DIRECTED_TICKS [18] = '{
    '{MODE_IDLE,  1'b0, 1'b1, 1'b0, 1'b0},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_SPARE, 1'b1, 1'b1, 1'b0, 1'b0},
    '{MODE_SPARE, 1'b0, 1'b1, 1'b0, 1'b0},
    '{calsr_pkg::MODE_ZERO, 1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_IDLE,  1'b0, 1'b1, 1'b0, 1'b1},
    '{calsr_pkg::MODE_READ, 1'b0, 1'b1, 1'b1, 1'b1},
    '{calsr_pkg::MODE_ZERO, 1'b1, 1'b1, 1'b1, 1'b1},
    '{MODE_SPARE, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  localparam timing_setting_t TIMING_PLAN [10] = '{
    '{16'd6,     16'd7,     32'h0001_0000, 1'b0, 8'd1},
    '{16'd0,     16'd0,     32'h0,         1'b1, 8'd2},
    '{16'd0,     16'd3,     32'h0,         1'b1, 8'd1},
    '{16'd3,     16'd4,     32'hFFFF_FFFF, 1'b0, 8'd1},
    '{16'd4,     16'd4,     32'h0,         1'b0, 8'd1},
    '{16'd9,     16'd3,     32'h0,         1'b1, 8'd1},
    '{16'hFFFF,  16'd1,     32'h0,         1'b1, 8'd2},
    '{16'd1,     16'd2,     32'h0001_0000, 1'b0, 8'd1},
    '{16'd2,     16'hFFFF,  32'h0,         1'b1, 8'd0},
    '{16'd1,     16'd1,     32'h0000_8000, 1'b0, 8'd2}
  };

  logic clk = 1'b0;
  logic rst_n;

  calsr_in_if  in_bus();
  calsr_out_if out_bus();
  calsr_cfg_if cfg_bus();

  caliper_serial_reader uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #2 clk = ~clk;

  // Reader model state, in the order in which transfers are accepted.
  logic [calsr_pkg::HIGH_W-1:0]   cfg_high   = calsr_pkg::HIGH_RESET;
  logic [calsr_pkg::PERIOD_W-1:0] cfg_period = calsr_pkg::PERIOD_RESET;
  logic [calsr_pkg::GAIN_W-1:0]   cfg_gain   = calsr_pkg::GAIN_RESET;
  logic                           rd_active  = 1'b0;
  logic                           rd_is_zero = 1'b0;
  logic [4:0]                     rd_bit     = '0;
  int unsigned                    rd_tick    = 0;
  logic [2:0]                     rd_votes   = '0;
  logic [calsr_pkg::FRAME_W-1:0]  rd_frame   = '0;
  logic [calsr_pkg::FRAME_W-1:0]  rd_offset  = '0;

  reading_t       expected_readings[$];
  typed_reading_t typed_readings[$];
  int             mismatches    = 0;
  int             readings_seen = 0;
  int             quiet_cycles  = 0;

  // Stimulus-side view of the frame in progress.
  int unsigned                   ticks_left = 0;
  int unsigned                   tick_pos   = 0;
  int unsigned                   bit_ticks  = 1;
  logic [calsr_pkg::FRAME_W-1:0] frame_word = '0;
  bit                            in_gaps_on    = 1'b1;
  bit                            out_stalls_on = 1'b1;

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [calsr_pkg::FRAME_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Offset-corrected frame times a Q16.16 gain, truncated toward zero and
  // clipped to the signed 32-bit range.
  function automatic logic [calsr_pkg::FRAME_W-1:0] scale_reading(
      input logic [calsr_pkg::FRAME_W-1:0] frame,
      input logic [calsr_pkg::FRAME_W-1:0] offset,
      input logic [calsr_pkg::GAIN_W-1:0] gain,
      output logic sat);
    longint     diff;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = longint'($signed(frame)) - longint'($signed(offset));
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = (mag * {32'b0, gain}) >> 16;
    sat  = 1'b0;
    if (diff >= 0) begin
      if (prod > 64'h7FFF_FFFF) begin
        prod = 64'h7FFF_FFFF;
        sat  = 1'b1;
      end
      return prod[31:0];
    end
    if (prod > 64'h8000_0000) begin
      prod = 64'h8000_0000;
      sat  = 1'b1;
    end
    return 32'h0 - prod[31:0];
  endfunction

  task automatic advance_reader(input logic [calsr_pkg::MODE_W-1:0] m, input logic d,
                                output reading_t r);
    int unsigned per;
    int unsigned hi;
    int unsigned t;
    int unsigned sample_at;
    logic        sat;
    r = '0;
    if (!rd_active && (m == calsr_pkg::MODE_READ || m == calsr_pkg::MODE_ZERO)) begin
      rd_active  = 1'b1;
      rd_is_zero = (m == calsr_pkg::MODE_ZERO);
      rd_bit     = '0;
      rd_tick    = 0;
      rd_votes   = '0;
      rd_frame   = '0;
    end
    if (rd_active) begin
      per       = (cfg_period == 0) ? 1 : cfg_period;
      hi        = (cfg_high > per) ? per : cfg_high;
      t         = (rd_tick >= per) ? per - 1 : rd_tick;
      sample_at = (hi == 0) ? 0 : hi - 1;
      r.clock_level = (t < hi);
      r.busy_res    = 1'b1;
      if (rd_is_zero) begin
        if (t == sample_at && d) rd_frame[rd_bit] = 1'b1;
      end else if (t < hi && t < VOTE_COUNT && d) begin
        rd_votes = rd_votes + 3'd1;
      end
      if (t + 1 >= per) begin
        if (!rd_is_zero && rd_votes >= VOTE_MAJORITY) rd_frame[rd_bit] = 1'b1;
        rd_votes = '0;
        rd_tick  = 0;
        if (rd_bit == 5'd31) begin
          rd_active = 1'b0;
          rd_bit    = '0;
          if (rd_is_zero) begin
            rd_offset   = rd_frame;
            r.zero_done = 1'b1;
          end else begin
            r.measurement  = scale_reading(rd_frame, rd_offset, cfg_gain, sat);
            r.saturated    = sat;
            r.result_valid = 1'b1;
          end
        end else begin
          rd_bit = rd_bit + 5'd1;
        end
      end else begin
        rd_tick = t + 1;
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t       want;
    reading_t       got;
    typed_reading_t note;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          calsr_pkg::REG_CLOCK_HIGH:   cfg_high   = cfg_bus.data[calsr_pkg::HIGH_W-1:0];
          calsr_pkg::REG_CLOCK_PERIOD: cfg_period = cfg_bus.data[calsr_pkg::PERIOD_W-1:0];
          calsr_pkg::REG_CAL_GAIN:     cfg_gain   = cfg_bus.data[calsr_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $error("result transfer with no expected reading");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          got.clock_level  = out_bus.clock_level;
          got.busy_res     = out_bus.busy_res;
          got.result_valid = out_bus.result_valid;
          got.zero_done    = out_bus.zero_done;
          got.measurement  = out_bus.measurement;
          got.saturated    = out_bus.saturated;
          check_field("clock_level", want.clock_level, got.clock_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("result_valid", want.result_valid, got.result_valid);
          check_field("zero_done", want.zero_done, got.zero_done);
          check_field("measurement", want.measurement, got.measurement);
          check_field("saturated", want.saturated, got.saturated);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        advance_reader(in_bus.mode, in_bus.data_level, want);
        note = typed_readings.pop_front();
        if (note.typed) want = note.value;
        expected_readings.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("caliper_serial_reader verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the queue fills
  // and the tick input backs up.
  initial begin
    int stall;
    bit hold_off_done;
    hold_off_done = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_off_done && readings_seen >= HOLD_OFF_AT) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        stall = pick_gap(out_stalls_on);
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic [calsr_pkg::MODE_W-1:0] m, input logic d,
                           input logic typed, input reading_t value);
    int gap;
    gap = pick_gap(in_gaps_on);
    if (ticks_left == 0 && (m == calsr_pkg::MODE_READ || m == calsr_pkg::MODE_ZERO)) begin
      bit_ticks  = (cfg_period == 0) ? 1 : cfg_period;
      ticks_left = calsr_pkg::FRAME_W * bit_ticks;
      tick_pos   = 0;
    end
    if (ticks_left != 0) begin
      ticks_left--;
      tick_pos++;
    end
    typed_readings.push_back('{typed, value});
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= m;
    in_bus.data_level <= d;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Mostly whole frames whose data line holds one bit per bit period, with
  // occasional flipped samples, stray requests and idle noise between frames.
  task automatic drive_frames(input int wanted);
    int                           started;
    int unsigned                  bitpos;
    logic [calsr_pkg::MODE_W-1:0] m;
    logic                         d;
    started = 0;
    while (ticks_left != 0 || started < wanted) begin
      if (ticks_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          m = $urandom_range(0, 1) ? MODE_IDLE : MODE_SPARE;
          send_tick(m, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          m = ($urandom_range(0, 3) == 0) ? calsr_pkg::MODE_ZERO : calsr_pkg::MODE_READ;
          frame_word = pick_word();
          d = frame_word[0] ^ ($urandom_range(0, 7) == 0);
          send_tick(m, d, 1'b0, '0);
          started++;
        end
      end else begin
        bitpos = tick_pos / bit_ticks;
        m = ($urandom_range(0, 15) == 0) ? calsr_pkg::MODE_W'($urandom_range(1, 3))
                                          : MODE_IDLE;
        d = frame_word[bitpos] ^ ($urandom_range(0, 7) == 0);
        send_tick(m, d, 1'b0, '0);
      end
    end
  endtask

  task automatic put_reg(input logic [calsr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [calsr_pkg::CFG_DAT_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [calsr_pkg::HIGH_W-1:0] high,
                               input logic [calsr_pkg::PERIOD_W-1:0] period,
                               input logic [calsr_pkg::GAIN_W-1:0] gain);
    put_reg(calsr_pkg::REG_CLOCK_HIGH, calsr_pkg::CFG_DAT_W'(high));
    put_reg(calsr_pkg::REG_CLOCK_PERIOD, calsr_pkg::CFG_DAT_W'(period));
    put_reg(calsr_pkg::REG_CAL_GAIN, gain);
    put_reg(REG_UNMAPPED, $urandom);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected reading has arrived and the pipeline is empty.
  task automatic settle_reader();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    reading_t                     row_reading;
    logic [calsr_pkg::GAIN_W-1:0] gain;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.mode       <= MODE_IDLE;
    in_bus.data_level <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= calsr_pkg::REG_CLOCK_HIGH;
    cfg_bus.data      <= '0;
    frame_word = pick_word();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Only the bit period is shortened; the clock-high time keeps its reset value.
    put_reg(calsr_pkg::REG_CLOCK_PERIOD, calsr_pkg::CFG_DAT_W'(DIRECTED_PERIOD));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_TICKS[i]) begin
      row_reading             = '0;
      row_reading.clock_level = DIRECTED_TICKS[i].clock_level;
      row_reading.busy_res    = DIRECTED_TICKS[i].busy_res;
      send_tick(DIRECTED_TICKS[i].mode, DIRECTED_TICKS[i].data, DIRECTED_TICKS[i].typed,
                row_reading);
    end
    drive_frames(0);
    settle_reader();

    foreach (TIMING_PLAN[p]) begin
      if (TIMING_PLAN[p].random_gain)
        gain = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0004_0000);
      else
        gain = TIMING_PLAN[p].gain;
      load_settings(TIMING_PLAN[p].high, TIMING_PLAN[p].period, gain);
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      // A bit period this long leaves no room for a frame; only idle ticks run here.
      if (TIMING_PLAN[p].frames == 0)
        repeat (40) send_tick($urandom_range(0, 1) ? MODE_IDLE : MODE_SPARE,
                              1'($urandom_range(0, 1)), 1'b0, '0);
      drive_frames(TIMING_PLAN[p].frames);
      settle_reader();
    end

    if (mismatches == 0)
      $display("caliper_serial_reader verification clean");
    else
      $display("caliper_serial_reader verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/calsr_pkg.sv
rtl/core/calsr_if.sv
rtl/core/calsr_front.sv
rtl/core/calsr_queue.sv
rtl/core/calsr_back.sv
rtl/core/caliper_serial_reader.sv
rtl/core/calsr_chk.sv
tb/sv/caliper_serial_reader_test.sv
